>>> hw/rtl/fses_pkg.sv
// package for floor span extraction and setup: payload types, register codes, states
`timescale 1ns / 1ps
package fses_pkg;

  typedef struct packed {
    logic [15:0] wall_height;
    logic        final_column;
  } fses_in_t;

  typedef struct packed {
    logic [5:0]         span_row;
    logic [8:0]         first_col;
    logic [8:0]         last_col;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic signed [15:0] frac_x;
    logic signed [15:0] frac_y;
    logic               zero_row_error;
    logic               last_span;
  } fses_out_t;

  localparam logic [2:0] REG_HALF_HEIGHT = 3'd0;
  localparam logic [2:0] REG_VIEW_WIDTH  = 3'd1;
  localparam logic [2:0] REG_PROJ_SCALE  = 3'd2;
  localparam logic [2:0] REG_VIEW_POS_X  = 3'd3;
  localparam logic [2:0] REG_VIEW_POS_Y  = 3'd4;
  localparam logic [2:0] REG_VIEW_SINE   = 3'd5;
  localparam logic [2:0] REG_VIEW_COSINE = 3'd6;

  localparam int HALF_ROWS   = 64;
  localparam int MAX_COLUMNS = 512;

  localparam int DIV_BITS = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_CLOSE_RD,
    ST_DIV_START,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_EMIT,
    ST_NEXT
  } fses_state_t;

  // signed trig value as used by the span math: bit 31 set negates the low 16 bits
  function automatic logic signed [32:0] trig_value(input logic [31:0] raw);
    if (raw[31]) begin
      trig_value = -$signed({17'd0, raw[15:0]});
    end else begin
      trig_value = $signed({1'b0, raw});
    end
  endfunction

endpackage

>>> hw/rtl/floor_span_extract_and_setup.sv
// top level: floor span extraction from column wall heights and span setup math
//
// in_ channel: one word per screen column (wall_height, final_column).
// out_ channel: one word per closed floor span, rows in increasing order;
//   last_span marks the final word caused by one column.
// cfg_ port: APB-style writes and reads of the seven view registers,
//   registers at byte address 4*i, 32-bit data.
// a column that only opens spans writes one start column to the span memory per cycle in
//   ST_OPEN, then retires in ST_NEXT before the next accept.
// each closed span passes through the memory read state ST_CLOSE_RD, a 32-step shared
//   radix-2 divider run three times (sine, cosine, distance), the multiply states ST_MUL1
//   and ST_MUL2, the output state ST_EMIT and the decision state ST_NEXT; the divider
//   sets the rate.
// a column that closes nothing is accepted in ST_IDLE and retired in ST_NEXT.
// reset loads the register defaults, sets the open row to the half height and
//   the column counter to zero; the span memory is not cleared.
// while out_stall is high the finished word holds in the output register and
//   the block waits in ST_EMIT before writing the next span's word.
`timescale 1ns / 1ps
module floor_span_extract_and_setup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fses_pkg::fses_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fses_pkg::fses_out_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import fses_pkg::*;

  localparam int RW = $clog2(HALF_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);

  // configuration
  logic [6:0]  half_height_r;
  logic [9:0]  view_width_r;
  logic [15:0] proj_scale_r;
  logic [31:0] pos_x_r, pos_y_r, sine_r, cosine_r;
  logic [2:0]  cfg_idx;

  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_height_r <= 7'd64;
      view_width_r  <= 10'd320;
      proj_scale_r  <= '0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      sine_r        <= '0;
      cosine_r      <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_HALF_HEIGHT: half_height_r <= cfg_pwdata[6:0];
        REG_VIEW_WIDTH:  view_width_r  <= cfg_pwdata[9:0];
        REG_PROJ_SCALE:  proj_scale_r  <= cfg_pwdata[15:0];
        REG_VIEW_POS_X:  pos_x_r       <= cfg_pwdata;
        REG_VIEW_POS_Y:  pos_y_r       <= cfg_pwdata;
        REG_VIEW_SINE:   sine_r        <= cfg_pwdata;
        REG_VIEW_COSINE: cosine_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HALF_HEIGHT: cfg_prdata = {25'd0, half_height_r};
      REG_VIEW_WIDTH:  cfg_prdata = {22'd0, view_width_r};
      REG_PROJ_SCALE:  cfg_prdata = {16'd0, proj_scale_r};
      REG_VIEW_POS_X:  cfg_prdata = pos_x_r;
      REG_VIEW_POS_Y:  cfg_prdata = pos_y_r;
      REG_VIEW_SINE:   cfg_prdata = sine_r;
      REG_VIEW_COSINE: cfg_prdata = cosine_r;
      default:         cfg_prdata = '0;
    endcase
  end

  logic [6:0] lim;
  assign lim = (half_height_r > 7'(HALF_ROWS)) ? 7'(HALF_ROWS) : half_height_r;

  // span start memory
  logic [CW-1:0] start_mem [HALF_ROWS];
  logic          mem_we;
  logic [RW-1:0] mem_waddr, mem_raddr;
  logic [CW-1:0] mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) start_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= start_mem[mem_raddr];
  end

  // control state
  fses_state_t   state_r, state_nxt;
  logic [6:0]    open_row_r, open_row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [6:0]    h_r, ctarget_r, ctarget_nxt;
  logic          fin_r;
  logic          phase_fin_r, phase_fin_nxt;
  logic [6:0]    h_in;
  logic [6:0]    open_row_lim;

  assign h_in = (in_data.wall_height[15:3] > 13'd127) ? 7'd127
              : 7'(in_data.wall_height[15:3]);

  // span math registers
  logic [1:0]          div_sel_r;
  logic [5:0]          div_cnt_r;
  logic [DIV_BITS-1:0] quo_r;
  logic [DIV_BITS:0]   rem_r;
  logic                div_neg_r;
  logic signed [15:0]  xs_r, ys_r;
  logic [31:0]         dist_r;
  logic [8:0]          first_r;
  logic [31:0]         mx_r, my_r;
  logic signed [31:0]  px_r, py_r;
  fses_out_t           out_r;
  logic                out_valid_r;

  logic [5:0] row6;
  assign row6 = open_row_r[5:0];

  logic signed [32:0] psin, pcos;
  assign psin = trig_value(sine_r);
  assign pcos = trig_value(cosine_r);

  // dividend selection: magnitude and sign
  logic [31:0] dvd_raw;
  logic [31:0] dvd_mag;
  logic        dvd_neg;
  always_comb begin
    unique case (div_sel_r)
      2'd0:    dvd_raw = psin[31:0] << 1;
      2'd1:    dvd_raw = pcos[31:0] << 1;
      default: dvd_raw = {1'b0, proj_scale_r, 15'd0};
    endcase
    dvd_neg = (div_sel_r != 2'd2) && dvd_raw[31];
    dvd_mag = dvd_neg ? (~dvd_raw + 32'd1) : dvd_raw;
  end

  logic [DIV_BITS:0] rem_sh;
  logic [DIV_BITS:0] rem_sub;
  assign rem_sh  = {rem_r[DIV_BITS-1:0], quo_r[DIV_BITS-1]};
  assign rem_sub = rem_sh - {26'd0, open_row_r};

  logic [31:0] quo_signed;
  assign quo_signed = div_neg_r ? (~quo_r + 32'd1) : quo_r;

  logic last_here;

  always_comb begin
    state_nxt     = state_r;
    open_row_nxt  = open_row_r;
    col_nxt       = col_r;
    ctarget_nxt   = ctarget_r;
    phase_fin_nxt = phase_fin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          phase_fin_nxt = 1'b0;
          ctarget_nxt   = (h_in > open_row_r) ? ((h_in > lim) ? lim : h_in) : 7'd0;
          if (h_in < open_row_r) state_nxt = ST_OPEN;
          else state_nxt = ST_NEXT;
        end
      end
      ST_OPEN: begin
        open_row_nxt = open_row_r - 7'd1;
        if (open_row_r - 7'd1 <= h_r) state_nxt = ST_NEXT;
      end
      ST_CLOSE_RD:  state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == 6'd0) begin
          if (div_sel_r == 2'd2) state_nxt = ST_MUL1;
          else state_nxt = ST_DIV_START;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          open_row_nxt = open_row_r + 7'd1;
          state_nxt    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        // decide the next span or retire the word
        if (open_row_r < ctarget_r) begin
          state_nxt = ST_CLOSE_RD;
        end else if (fin_r && !phase_fin_r) begin
          phase_fin_nxt = 1'b1;
          ctarget_nxt   = lim;
          if (open_row_r < lim) state_nxt = ST_CLOSE_RD;
          else state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
        end
        if (state_nxt == ST_IDLE) begin
          if (fin_r) begin
            open_row_nxt = lim;
            col_nxt      = '0;
          end else begin
            col_nxt = (32'(col_r) + 32'd1 >= 32'(MAX_COLUMNS)) ? '0 : col_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign open_row_lim = open_row_r;

  // after the current span, is another one coming for this word
  always_comb begin
    if (open_row_r + 7'd1 < ctarget_r) last_here = 1'b0;
    else if (fin_r && !phase_fin_r && (open_row_r + 7'd1 < lim)) last_here = 1'b0;
    else last_here = 1'b1;
  end

  always_comb begin
    mem_we    = (state_r == ST_OPEN) && (open_row_r - 7'd1 < 7'(HALF_ROWS));
    mem_waddr = RW'(open_row_r - 7'd1);
    mem_wdata = col_r;
    mem_raddr = RW'(open_row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      open_row_r  <= (7'd64 > 7'(HALF_ROWS)) ? 7'(HALF_ROWS) : 7'd64;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      phase_fin_r <= 1'b0;
      ctarget_r   <= '0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_row_r  <= open_row_nxt;
      col_r       <= col_nxt;
      phase_fin_r <= phase_fin_nxt;
      ctarget_r   <= ctarget_nxt;
      if (state_r == ST_IDLE && in_valid) fin_r <= in_data.final_column;
      if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath
  logic signed [31:0] fx, fy;
  logic signed [31:0] pre;
  logic signed [31:0] dist_sh;
  logic signed [31:0] tcos, tsin;
  assign dist_sh = $signed({8'd0, dist_r[31:8]});
  assign tcos = 32'(pcos >>> 8);
  assign tsin = 32'(psin >>> 8);
  assign pre  = $signed({23'd0, view_width_r[9:1]}) - $signed({23'd0, first_r});

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) h_r <= h_in;
    if (state_r == ST_CLOSE_RD) div_sel_r <= 2'd0;
    if (state_r == ST_DIV_START) begin
      if (div_sel_r == 2'd0) first_r <= mem_rdata_r;
      quo_r     <= dvd_mag;
      rem_r     <= '0;
      div_neg_r <= dvd_neg;
      div_cnt_r <= 6'(DIV_BITS);
    end
    if (state_r == ST_DIV) begin
      if (div_cnt_r != 6'd0) begin
        div_cnt_r <= div_cnt_r - 6'd1;
        if (!rem_sub[DIV_BITS]) begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[DIV_BITS-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[DIV_BITS-2:0], 1'b0};
        end
      end else begin
        unique case (div_sel_r)
          2'd0:    xs_r   <= quo_signed[15:0];
          2'd1:    ys_r   <= quo_signed[15:0];
          default: dist_r <= quo_r;
        endcase
        div_sel_r <= div_sel_r + 2'd1;
      end
    end
    if (state_r == ST_MUL1) begin
      mx_r <= 32'(dist_sh * tcos);
      my_r <= 32'(dist_sh * tsin);
    end
    if (state_r == ST_MUL2) begin
      px_r <= 32'(($signed(xs_r) >>> 2) * pre);
      py_r <= 32'(($signed(ys_r) >>> 2) * pre);
    end
    if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_r.span_row  <= row6;
      out_r.first_col <= first_r;
      out_r.last_col  <= phase_fin_r ? col_r : col_r - 9'd1;
      out_r.last_span <= last_here;
      if (open_row_r == 7'd0) begin
        out_r.zero_row_error <= 1'b1;
        out_r.step_x <= '0;
        out_r.step_y <= '0;
        out_r.frac_x <= '0;
        out_r.frac_y <= '0;
      end else begin
        out_r.zero_row_error <= 1'b0;
        out_r.step_x <= xs_r;
        out_r.step_y <= ys_r;
        out_r.frac_x <= fx[15:0];
        out_r.frac_y <= fy[15:0];
      end
    end
  end

  assign fx = pos_x_r + mx_r - px_r;
  assign fy = pos_y_r - my_r - py_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  a_open_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (open_row_lim <= 7'(HALF_ROWS)))
    else $error("open row beyond rows");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == ST_EMIT) |=> (state_r == ST_EMIT))
    else $error("span left emit while output stalled");
endmodule
